### rtl/core/bur_pkg.sv
// ----------------------------------------------------------------------------
// bur_pkg
// Shared constants, types and index helpers for the bounded undo/redo stacks.
// ----------------------------------------------------------------------------
package bur_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_UNDO   = 2'd1;
  localparam logic [1:0] ACT_REDO   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [15:0] name;
    logic [31:0] record;
    logic        delta;
    logic [31:0] param;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic fetch;
  } stack_cmd_t;

  typedef struct packed {
    logic   nonempty;
    logic   full;
    logic   multi;
    entry_t top;
  } stack_stat_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } ctl_t;

  // Reduce a ring position below twice the depth back into range
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] pos);
    logic [SUM_W-1:0] r;
    r = (pos >= SUM_W'(DEPTH)) ? pos - SUM_W'(DEPTH) : pos;
    return r[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/bur_stack.sv
// ----------------------------------------------------------------------------
// bur_stack
// One bounded stack: ring memory, head and count, and a cached top entry.
// ----------------------------------------------------------------------------
module bur_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  bur_pkg::stack_cmd_t  cmd,
  input  bur_pkg::entry_t      push_entry,
  output bur_pkg::stack_stat_t stat
);
  import bur_pkg::*;

  entry_t           mem [DEPTH];
  entry_t           rd_data;
  entry_t           top;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             full;

  assign full    = (count == CNT_W'(DEPTH));
  assign wr_addr = full ? head : wrap_idx(SUM_W'(head) + SUM_W'(count));
  // entry just below the top; only used while two or more are held
  assign rd_addr = wrap_idx(SUM_W'(head) + SUM_W'(count) - SUM_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      if (full) begin
        head <= wrap_idx(SUM_W'(head) + SUM_W'(1));
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_entry;
    end
    if (cmd.pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= push_entry;
    end else if (cmd.fetch) begin
      top <= rd_data;
    end
  end

  assign stat.nonempty = (count != '0);
  assign stat.full     = full;
  assign stat.multi    = (count > CNT_W'(1));
  assign stat.top      = top;

endmodule

### rtl/core/bur_ctrl.sv
// ----------------------------------------------------------------------------
// bur_ctrl
// Sequencer: takes one transaction, issues stack commands, refetches a
// popped top, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bur_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_busy,
  input  logic [1:0]           act,
  input  logic                 merge_hit,
  input  bur_pkg::stack_stat_t undo_st,
  input  bur_pkg::stack_stat_t redo_st,
  output bur_pkg::ctl_t        ctl,
  output bur_pkg::stack_cmd_t  undo_cmd,
  output bur_pkg::stack_cmd_t  redo_cmd
);
  import bur_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl         = '0;
    undo_cmd    = '0;
    redo_cmd    = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_DONE;
        unique case (act)
          ACT_RECORD: begin
            redo_cmd.clear = 1'b1;
            undo_cmd.push  = !merge_hit;
          end
          ACT_UNDO: begin
            if (undo_st.nonempty) begin
              undo_cmd.pop  = 1'b1;
              redo_cmd.push = 1'b1;
              if (undo_st.multi) begin
                state_next = S_FETCH;
              end
            end
          end
          ACT_REDO: begin
            if (redo_st.nonempty) begin
              redo_cmd.pop  = 1'b1;
              undo_cmd.push = 1'b1;
              if (redo_st.multi) begin
                state_next = S_FETCH;
              end
            end
          end
          ACT_CLEAR: begin
            undo_cmd.clear = 1'b1;
            redo_cmd.clear = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_FETCH: begin
        // refresh the cached top of the stack that was popped
        undo_cmd.fetch = (act == ACT_UNDO);
        redo_cmd.fetch = (act == ACT_REDO);
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bounded_undo_redo_stacks.sv
// ----------------------------------------------------------------------------
// bounded_undo_redo_stacks
// Two bounded undo/redo history stacks with edit coalescing.
// ----------------------------------------------------------------------------
//  Channel | Handshake                | Payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid / in_ready      | action, name_handle, record_handle,
//          |                          | is_delta, param_id, time_stamp
//  out     | out_valid / out_ready    | undo_* / redo_* tops, coalesced,
//          |                          | dropped_oldest
//  cfg     | cfg_wr_en (no wait)      | cfg_wr_data: coalescing window
//
// After acceptance a transaction passes through the exec and done states, with
// a fetch state between them when a commit pops a stack holding two or more
// entries: the new top is read from that stack's memory, whose read data is registered.
// The result sits in an output register; the next transaction is accepted
// while it waits, and only completion of that next one stalls on out_ready.
// Reset empties both stacks at once; stack memory needs no clearing.
// ----------------------------------------------------------------------------
module bounded_undo_redo_stacks (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] name_handle,
  input  logic [31:0] record_handle,
  input  logic        is_delta,
  input  logic [31:0] param_id,
  input  logic [31:0] time_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        undo_valid,
  output logic [15:0] undo_name,
  output logic [31:0] undo_record,
  output logic        undo_delta,
  output logic [31:0] undo_param,
  output logic        redo_valid,
  output logic [15:0] redo_name,
  output logic [31:0] redo_record,
  output logic        redo_delta,
  output logic [31:0] redo_param,
  output logic        coalesced,
  output logic        dropped_oldest,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import bur_pkg::*;

  logic [31:0] coalescing_window;
  logic [1:0]  act;
  entry_t      item;
  logic        merge_hit;
  logic        merged;
  logic        dropped;
  logic [31:0] since;
  entry_t      undo_push;
  entry_t      redo_push;
  ctl_t        ctl;
  stack_cmd_t  undo_cmd;
  stack_cmd_t  redo_cmd;
  stack_stat_t undo_st;
  stack_stat_t redo_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      coalescing_window <= '0;
    end else if (cfg_wr_en) begin
      coalescing_window <= cfg_wr_data;
    end
  end

  // hold the transaction while it is worked on
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      act          <= action;
      item.name    <= name_handle;
      item.record  <= record_handle;
      item.delta   <= is_delta;
      item.param   <= param_id;
      item.stamp   <= time_stamp;
    end
  end

  // ticks since the undo top, modulo 2^32
  assign since     = item.stamp - undo_st.top.stamp;
  assign merge_hit = undo_st.nonempty && (since < coalescing_window) && item.delta &&
                     undo_st.top.delta && (undo_st.top.param == item.param);

  // a moved entry keeps its name and time, and takes the given inverse
  always_comb begin
    redo_push        = item;
    redo_push.name   = undo_st.top.name;
    redo_push.stamp  = undo_st.top.stamp;
    undo_push        = item;
    if (act == ACT_REDO) begin
      undo_push.name  = redo_st.top.name;
      undo_push.stamp = redo_st.top.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      merged  <= (act == ACT_RECORD) && merge_hit;
      dropped <= (undo_cmd.push && undo_st.full) || (redo_cmd.push && redo_st.full);
    end
  end

  bur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_busy  (out_valid && !out_ready),
    .act       (act),
    .merge_hit (merge_hit),
    .undo_st   (undo_st),
    .redo_st   (redo_st),
    .ctl       (ctl),
    .undo_cmd  (undo_cmd),
    .redo_cmd  (redo_cmd)
  );

  bur_stack u_undo (
    .clk        (clk),
    .rst        (rst),
    .cmd        (undo_cmd),
    .push_entry (undo_push),
    .stat       (undo_st)
  );

  bur_stack u_redo (
    .clk        (clk),
    .rst        (rst),
    .cmd        (redo_cmd),
    .push_entry (redo_push),
    .stat       (redo_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // an empty stack shows zero fields
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      undo_valid     <= undo_st.nonempty;
      undo_name      <= undo_st.nonempty ? undo_st.top.name   : '0;
      undo_record    <= undo_st.nonempty ? undo_st.top.record : '0;
      undo_delta     <= undo_st.nonempty && undo_st.top.delta;
      undo_param     <= undo_st.nonempty ? undo_st.top.param  : '0;
      redo_valid     <= redo_st.nonempty;
      redo_name      <= redo_st.nonempty ? redo_st.top.name   : '0;
      redo_record    <= redo_st.nonempty ? redo_st.top.record : '0;
      redo_delta     <= redo_st.nonempty && redo_st.top.delta;
      redo_param     <= redo_st.nonempty ? redo_st.top.param  : '0;
      coalesced      <= merged;
      dropped_oldest <= dropped;
    end
  end

endmodule

### rtl/core/bur_checker.sv
// ----------------------------------------------------------------------------
// bur_checker
// Port-level checks for the undo/redo stacks, bound to the top level.
// ----------------------------------------------------------------------------
module bur_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        undo_valid,
  input logic [15:0] undo_name,
  input logic [31:0] undo_record,
  input logic        undo_delta,
  input logic [31:0] undo_param,
  input logic        redo_valid,
  input logic [31:0] redo_record,
  input logic        coalesced,
  input logic        dropped_oldest
);

  // a merge needs a non-empty undo and a record, which empties redo
  a_merge_tops: assert property (@(posedge clk) disable iff (rst)
    out_valid && coalesced |-> undo_valid && !redo_valid && !dropped_oldest)
    else $error("coalesced result with inconsistent stack tops");

  // empty stacks show zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !undo_valid |-> undo_name == 16'd0 && undo_record == 32'd0 &&
                                 !undo_delta && undo_param == 32'd0)
    else $error("empty undo stack shows non-zero top");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(undo_record) && $stable(redo_record))
    else $error("stalled result changed");

endmodule

bind bounded_undo_redo_stacks bur_checker u_bur_checker (.*);
